/* hw/rtl/zbsc_pkg.sv */
// Shared types and constants for the zero-block singularity check.
// Used by the front end, the row queue and the check engine; depends on nothing.
`timescale 1ns / 1ps

package zbsc_pkg;

    localparam int ROW_W       = 32;
    localparam int CFG_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ROW_W-1:0] mask;
        logic             store;
        logic             last;
        logic [CFG_W-1:0] idx;
        logic [CFG_W-1:0] size;
        logic [CFG_W-1:0] loaded;
    } t_row_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hw/rtl/zbsc_front.sv */
// Front end: size register, item acceptance and row classification.
// Depends on zbsc_pkg; feeds entries into zbsc_queue.
`timescale 1ns / 1ps

module zbsc_front #(
    parameter int MAX_SIZE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [zbsc_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                          i_start,
    input  logic [zbsc_pkg::ROW_W-1:0]    i_row_nonzero_mask,
    input  logic                          i_last_row,
    input  zbsc_pkg::t_q_status           i_q_status,
    output logic                          o_busy,
    output logic                          o_push,
    output zbsc_pkg::t_row_entry          o_entry
);
    import zbsc_pkg::*;

    localparam logic [CFG_W:0] MAX_N = (CFG_W + 1)'(MAX_SIZE);

    logic [CFG_W-1:0] r_size;
    logic [CFG_W-1:0] r_loaded;
    logic [CFG_W-1:0] n_loaded;
    logic [CFG_W-1:0] eff_size;
    logic             store;
    logic             accept;

    assign eff_size = ({1'b0, r_size} > MAX_N) ? MAX_N[CFG_W-1:0] : r_size;
    assign store    = r_loaded < eff_size;
    assign n_loaded = store ? r_loaded + 1'b1 : r_loaded;
    assign o_busy   = i_q_status.full;
    assign accept   = i_start && !o_busy;
    assign o_push   = accept;

    always_comb begin
        o_entry.mask   = i_row_nonzero_mask;
        o_entry.store  = store;
        o_entry.last   = i_last_row;
        o_entry.idx    = r_loaded;
        o_entry.size   = eff_size;
        o_entry.loaded = n_loaded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= '0;
            r_loaded <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
            if (accept) begin
                r_loaded <= i_last_row ? '0 : n_loaded;
            end
        end
    end

endmodule

/* hw/rtl/zbsc_queue.sv */
// Two-entry queue of classified rows between the front end and the check engine.
// Depends on zbsc_pkg.
`timescale 1ns / 1ps

module zbsc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  zbsc_pkg::t_row_entry  i_entry,
    input  logic                  i_pop,
    output zbsc_pkg::t_row_entry  o_entry,
    output zbsc_pkg::t_q_status   o_status
);
    import zbsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_row_entry       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/zbsc_back.sv */
// Check engine: row memory, zero counts, rank sort and ordered column scan.
// Depends on zbsc_pkg; drains entries from zbsc_queue and drives the result.
`timescale 1ns / 1ps

module zbsc_back #(
    parameter int MAX_SIZE = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  zbsc_pkg::t_row_entry  i_entry,
    input  zbsc_pkg::t_q_status   i_q_status,
    output logic                  o_pop,
    output logic                  o_result_valid,
    output logic                  o_has_zero_block
);
    import zbsc_pkg::*;

    localparam int IW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW   = $clog2(MAX_SIZE + 1);
    localparam int COLS = (MAX_SIZE > ROW_W) ? MAX_SIZE : ROW_W;
    localparam int PW   = $clog2(COLS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZC_RD,
        S_ZC_WR,
        S_RK_KEY,
        S_RK_KEYW,
        S_RK_SCAN,
        S_SC_ORD,
        S_SC_ROW,
        S_SC_EVAL
    } t_state;

    t_state            r_state;
    logic              r_valid;
    logic              r_result;
    logic [NW-1:0]     r_n;
    logic [COLS-1:0]   r_cm;
    logic [COLS-1:0]   r_seen;
    logic [NW-1:0]     r_i;
    logic [NW-1:0]     r_j;
    logic [NW-1:0]     r_pj;
    logic              r_pv;
    logic [NW-1:0]     r_key;
    logic [NW-1:0]     r_rank;
    logic [NW-1:0]     r_mc;
    logic [NW-1:0]     r_p;
    logic              r_any_full;

    logic [ROW_W-1:0]  r_row_mem [MAX_SIZE];
    logic [NW-1:0]     r_zc_mem  [MAX_SIZE];
    logic [IW-1:0]     r_ord_mem [MAX_SIZE];
    logic [ROW_W-1:0]  r_rd_row;
    logic [NW-1:0]     r_rd_zc;
    logic [IW-1:0]     r_rd_ord;

    logic              row_we;
    logic              row_re;
    logic [IW-1:0]     row_raddr;
    logic              zc_we;
    logic              zc_re;
    logic [IW-1:0]     zc_raddr;
    logic              ord_we;
    logic              ord_re;

    logic [COLS-1:0]   row_cols;
    logic [NW-1:0]     zc_row;
    logic              row_full;
    logic [NW-1:0]     open_zc;
    logic              scan_fail;
    logic              rank_inc;
    logic [NW-1:0]     rank_next;
    logic              rank_done;
    logic [NW:0]       rank_sum;
    logic [NW-1:0]     mc_cand;
    logic              mc_hit;
    logic [NW-1:0]     n_mc;

    function automatic logic [PW-1:0] popcount(input logic [COLS-1:0] v);
        logic [PW-1:0] c;
        c = '0;
        for (int k = 0; k < COLS; k++) begin
            c = c + PW'(v[k]);
        end
        return c;
    endfunction

    assign o_pop            = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_result_valid   = r_valid;
    assign o_has_zero_block = r_result;

    assign row_cols  = COLS'(r_rd_row) & r_cm;
    assign zc_row    = r_n - NW'(popcount(row_cols));
    assign row_full  = zc_row == r_n;
    assign open_zc   = NW'(popcount(r_cm & ~r_seen & ~row_cols));
    assign scan_fail = ({1'b0, open_zc} + {1'b0, r_p}) > {1'b0, r_n};

    assign rank_inc  = r_pv && ((r_rd_zc > r_key) || ((r_rd_zc == r_key) && (r_pj < r_i)));
    assign rank_next = r_rank + NW'(rank_inc);
    assign rank_done = r_pv && (r_pj == r_n - 1'b1);
    assign rank_sum  = {1'b0, rank_next} + {1'b0, r_key};
    assign mc_cand   = rank_next + 1'b1;
    assign mc_hit    = (rank_next != '0) && (rank_sum >= {1'b0, r_n});
    assign n_mc      = (mc_hit && (mc_cand > r_mc)) ? mc_cand : r_mc;

    assign row_we    = o_pop && i_entry.store;
    assign row_re    = (r_state == S_ZC_RD) || (r_state == S_SC_ROW);
    assign row_raddr = (r_state == S_SC_ROW) ? r_rd_ord : r_i[IW-1:0];
    assign zc_we     = r_state == S_ZC_WR;
    assign zc_re     = (r_state == S_RK_KEY) || ((r_state == S_RK_SCAN) && (r_j < r_n));
    assign zc_raddr  = (r_state == S_RK_KEY) ? r_i[IW-1:0] : r_j[IW-1:0];
    assign ord_we    = (r_state == S_RK_SCAN) && rank_done;
    assign ord_re    = r_state == S_SC_ORD;

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_row_mem[i_entry.idx[IW-1:0]] <= i_entry.mask;
        end
        if (row_re) begin
            r_rd_row <= r_row_mem[row_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (zc_we) begin
            r_zc_mem[r_i[IW-1:0]] <= zc_row;
        end
        if (zc_re) begin
            r_rd_zc <= r_zc_mem[zc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_ord_mem[rank_next[IW-1:0]] <= r_i[IW-1:0];
        end
        if (ord_re) begin
            r_rd_ord <= r_ord_mem[r_p[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_entry.last) begin
                        if (i_entry.size == '0) begin
                            r_valid  <= 1'b1;
                            r_result <= 1'b0;
                        end else if (i_entry.loaded < i_entry.size) begin
                            r_valid  <= 1'b1;
                            r_result <= 1'b1;
                        end else begin
                            r_n        <= NW'(i_entry.size);
                            r_cm       <= ~({COLS{1'b1}} << i_entry.size);
                            r_i        <= '0;
                            r_any_full <= 1'b0;
                            r_state    <= S_ZC_RD;
                        end
                    end
                end
                S_ZC_RD: begin
                    r_state <= S_ZC_WR;
                end
                S_ZC_WR: begin
                    if (r_i == r_n - 1'b1) begin
                        if (r_any_full || row_full) begin
                            r_valid  <= 1'b1;
                            r_result <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_i     <= '0;
                            r_mc    <= '0;
                            r_state <= S_RK_KEY;
                        end
                    end else begin
                        r_any_full <= r_any_full || row_full;
                        r_i        <= r_i + 1'b1;
                        r_state    <= S_ZC_RD;
                    end
                end
                S_RK_KEY: begin
                    r_state <= S_RK_KEYW;
                end
                S_RK_KEYW: begin
                    r_key   <= r_rd_zc;
                    r_rank  <= '0;
                    r_j     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_RK_SCAN;
                end
                S_RK_SCAN: begin
                    r_pv <= r_j < r_n;
                    r_pj <= r_j;
                    if (r_j < r_n) begin
                        r_j <= r_j + 1'b1;
                    end
                    if (r_pv) begin
                        r_rank <= rank_next;
                    end
                    if (rank_done) begin
                        r_mc <= n_mc;
                        if (r_i == r_n - 1'b1) begin
                            if (n_mc == '0) begin
                                r_valid  <= 1'b1;
                                r_result <= 1'b0;
                                r_state  <= S_IDLE;
                            end else begin
                                r_p     <= '0;
                                r_seen  <= '0;
                                r_state <= S_SC_ORD;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RK_KEY;
                        end
                    end
                end
                S_SC_ORD: begin
                    r_state <= S_SC_ROW;
                end
                S_SC_ROW: begin
                    r_state <= S_SC_EVAL;
                end
                S_SC_EVAL: begin
                    r_seen <= r_seen | row_cols;
                    if (scan_fail) begin
                        r_valid  <= 1'b1;
                        r_result <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (r_p == r_mc - 1'b1) begin
                        r_valid  <= 1'b1;
                        r_result <= 1'b0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_SC_ORD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rank_compare_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RK_SCAN && r_pv) |-> (r_pj < r_n))
        else $error("Rank compare uses a row beyond the matrix size.");

    a_rank_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ord_we |-> (rank_next < r_n))
        else $error("Sorted position falls outside the matrix.");

    a_key_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RK_KEY) |-> (r_i < r_n))
        else $error("Ranking started on a row beyond the matrix size.");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_ORD) |-> (r_p < r_mc && r_mc <= r_n))
        else $error("Column scan runs past the rows it has to check.");

endmodule

/* hw/rtl/zero_block_singularity_check.sv */
// Top level of the zero-block singularity check: front end, row queue, check engine.
// Depends on zbsc_pkg, zbsc_front, zbsc_queue and zbsc_back.
//
// Channel   Handshake                    Payload
// input     start, busy                  i_row_nonzero_mask, i_last_row
// config    i_cfg_wr_en                  i_cfg_wr_data (matrix size)
// result    o_result_valid (one cycle)   o_has_zero_block
//
// Rows are taken one per cycle while busy is low, and rows up to the matrix size are stored;
// a two-entry queue sits in front of the engine. On the last row the engine runs the check, whose
// length is set by the single read port of the zero-count memory during ranking.
// Reset is synchronous and active low; the row memories are not cleared.
// busy is high while the queue is full, which can happen when rows arrive while a check is running.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module zero_block_singularity_check #(
    parameter int MAX_SIZE = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [zbsc_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [zbsc_pkg::ROW_W-1:0]    i_row_nonzero_mask,
    input  logic                          i_last_row,
    output logic                          o_result_valid,
    output logic                          o_has_zero_block
);
    import zbsc_pkg::*;

    t_row_entry push_entry;
    t_row_entry head_entry;
    t_q_status  q_status;
    logic       push;
    logic       pop;

    zbsc_front #(
        .MAX_SIZE(MAX_SIZE)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_start            (start),
        .i_row_nonzero_mask (i_row_nonzero_mask),
        .i_last_row         (i_last_row),
        .i_q_status         (q_status),
        .o_busy             (busy),
        .o_push             (push),
        .o_entry            (push_entry)
    );

    zbsc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    zbsc_back #(
        .MAX_SIZE(MAX_SIZE)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (head_entry),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_result_valid   (o_result_valid),
        .o_has_zero_block (o_has_zero_block)
    );

endmodule

/* tb/sv/zero_block_singularity_check_tb.sv */
// Testbench for zero_block_singularity_check: directed and random matrices, checked by a scoreboard.
// The scoreboard predicts each singularity answer from the accepted rows and the matrix size.
// Depends on zbsc_pkg and zero_block_singularity_check.
`timescale 1ns / 1ps

class zero_block_scoreboard;
    logic [zbsc_pkg::CFG_W-1:0] size_reg;
    logic [zbsc_pkg::ROW_W-1:0] row_masks [32];
    int unsigned                rows_held;
    logic                       expected_flags [$];
    int unsigned                checks_done;
    int unsigned                blocks_found;
    int unsigned                mismatches;

    function new();
        size_reg     = '0;
        rows_held    = 0;
        checks_done  = 0;
        blocks_found = 0;
        mismatches   = 0;
        foreach (row_masks[k]) begin
            row_masks[k] = '0;
        end
    endfunction

    function void set_size(logic [zbsc_pkg::CFG_W-1:0] value);
        size_reg = value;
    endfunction

    function int unsigned active_size();
        return (size_reg > 32) ? 32 : int'(size_reg);
    endfunction

    function logic predict_zero_block();
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned key;
        int unsigned walk_rows;
        int unsigned open_zeros;
        int unsigned zeros [32];
        int unsigned order [32];
        logic [31:0] cols_in_use;
        logic [31:0] row;
        logic [31:0] seen;
        n = active_size();
        if (n == 0) begin
            return 1'b0;
        end
        cols_in_use = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        for (i = 0; i < n; i++) begin
            row      = (i < rows_held) ? (row_masks[i] & cols_in_use) : '0;
            zeros[i] = n - $countones(row);
            order[i] = i;
        end
        for (i = 1; i < n; i++) begin
            key = order[i];
            j   = i;
            while (j > 0 && zeros[order[j-1]] < zeros[key]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        if (zeros[order[0]] == n) begin
            return 1'b1;
        end
        walk_rows = 0;
        for (i = 1; i < n; i++) begin
            if (i + zeros[order[i]] >= n) begin
                walk_rows = i + 1;
            end
        end
        seen = '0;
        for (i = 0; i < walk_rows; i++) begin
            row        = (order[i] < rows_held) ? (row_masks[order[i]] & cols_in_use) : '0;
            open_zeros = $countones(cols_in_use & ~seen & ~row);
            seen       = seen | row;
            if (open_zeros + i > n) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void note_row(logic [zbsc_pkg::ROW_W-1:0] mask, logic last);
        int unsigned n;
        n = active_size();
        if (rows_held < n && rows_held < 32) begin
            row_masks[rows_held] = mask;
            rows_held++;
        end
        if (last) begin
            expected_flags.push_back(predict_zero_block());
            rows_held = 0;
        end
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endtask

    task check_flag(logic got);
        logic want;
        if (expected_flags.size() == 0) begin
            report_mismatch($sformatf("result %0b with no check pending", got));
        end else begin
            want = expected_flags.pop_front();
            checks_done++;
            if (want) begin
                blocks_found++;
            end
            if (got !== want) begin
                report_mismatch($sformatf("check %0d: has_zero_block %0b, expected %0b",
                                          checks_done, got, want));
            end
        end
    endtask
endclass

module zero_block_singularity_check_tb;
    localparam int unsigned ITEM_TARGET = 500;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [zbsc_pkg::CFG_W-1:0] i_cfg_wr_data;
    logic                       start;
    logic                       busy;
    logic [zbsc_pkg::ROW_W-1:0] i_row_nonzero_mask;
    logic                       i_last_row;
    logic                       o_result_valid;
    logic                       o_has_zero_block;

    zero_block_scoreboard sb = new();
    int unsigned          rows_sent   = 0;
    int unsigned          size_writes = 0;
    int unsigned          burst_left  = 0;

    zero_block_singularity_check #(
        .MAX_SIZE(32)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .start              (start),
        .busy               (busy),
        .i_row_nonzero_mask (i_row_nonzero_mask),
        .i_last_row         (i_last_row),
        .o_result_valid     (o_result_valid),
        .o_has_zero_block   (o_has_zero_block)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    initial begin
        #15_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            sb.check_flag(o_has_zero_block);
        end
    end

    function automatic int unsigned settle_cycles(int unsigned n);
        return n * n + 8 * n + 40;
    endfunction

    function automatic logic [31:0] pick_bits(int unsigned limit, int unsigned count);
        logic [31:0] bits;
        int unsigned got;
        int unsigned j;
        bits = '0;
        got  = 0;
        if (count > limit) begin
            count = limit;
        end
        while (got < count) begin
            j = $urandom_range(limit - 1, 0);
            if (!bits[j]) begin
                bits[j] = 1'b1;
                got++;
            end
        end
        return bits;
    endfunction

    function automatic logic [31:0] random_row();
        case ($urandom_range(11, 0))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom & $urandom & $urandom;
            4, 5:    return $urandom & $urandom;
            6, 7:    return $urandom;
            8, 9:    return $urandom | $urandom;
            default: return $urandom | $urandom | $urandom;
        endcase
    endfunction

    task automatic send_row(input logic [31:0] mask, input logic last);
        @(negedge i_clk);
        start              = 1'b1;
        i_row_nonzero_mask = mask;
        i_last_row         = last;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sb.note_row(mask, last);
        rows_sent++;
    endtask

    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(9, 0) < 7) ? $urandom_range(4, 1) : $urandom_range(40, 5);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.expected_flags.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle_cycles(sb.active_size())) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [zbsc_pkg::CFG_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.set_size(value);
        size_writes++;
    endtask

    task automatic send_random_matrix();
        int unsigned n;
        int unsigned count;
        int unsigned kind;
        int unsigned shape;
        int unsigned r;
        int unsigned c;
        int unsigned m;
        int unsigned k;
        logic [31:0] rows [36];
        logic [31:0] cols;
        logic [31:0] row_sel;
        logic        noise_last;
        n          = sb.active_size();
        kind       = $urandom_range(9, 0);
        noise_last = 1'($urandom_range(1, 0));
        if (kind <= 6) begin
            count = (n == 0) ? 1 : n;
        end else if (kind == 7) begin
            count = (n > 1) ? $urandom_range(n - 1, 1) : 1;
        end else if (kind == 8) begin
            count = n + $urandom_range(3, 1);
        end else begin
            count = 1;
        end
        for (k = 0; k < count; k++) begin
            rows[k] = random_row();
        end
        shape = $urandom_range(3, 0);
        if (n >= 2 && shape >= 2) begin
            if (shape == 2) begin
                r = $urandom_range(n, 1);
                c = n + 1 - r;
            end else begin
                r = $urandom_range(n - 1, 1);
                c = n - r;
            end
            m       = (count < n) ? count : n;
            row_sel = pick_bits(m, r);
            cols    = pick_bits(n, c);
            for (k = 0; k < m; k++) begin
                if (row_sel[k]) begin
                    rows[k] = rows[k] & ~cols;
                end
            end
        end
        for (k = 0; k < count; k++) begin
            pace();
            send_row(rows[k], (kind == 9) ? noise_last : (k == count - 1));
        end
    endtask

    initial begin
        int unsigned sel;
        int unsigned matrices;
        int unsigned t;
        int unsigned wait_cycles;
        logic [zbsc_pkg::CFG_W-1:0] next_size;

        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        start              = 1'b0;
        i_row_nonzero_mask = '0;
        i_last_row         = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_size(6'd0);
        send_row(32'hFFFF_FFFF, 1'b1);
        write_size(6'd1);
        send_row(32'h0000_0000, 1'b1);
        send_row(32'h0000_0001, 1'b1);
        send_row(32'hFFFF_FFFE, 1'b1);
        write_size(6'd2);
        send_row(32'h0000_0001, 1'b0);
        send_row(32'h0000_0002, 1'b1);
        send_row(32'h0000_0003, 1'b0);
        send_row(32'h0000_0000, 1'b1);
        send_row(32'h0000_0001, 1'b0);
        send_row(32'h0000_0001, 1'b1);
        // A lone last row leaves the remaining rows missing, so they count as all zero.
        write_size(6'd3);
        send_row(32'h0000_0007, 1'b1);
        // Rows beyond the matrix size are dropped.
        write_size(6'd2);
        send_row(32'h0000_0002, 1'b0);
        send_row(32'h0000_0001, 1'b0);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'h0000_0003, 1'b1);
        // The size is changed while a matrix is half loaded, downward and then upward.
        write_size(6'd4);
        send_row(32'h0000_0005, 1'b0);
        send_row(32'h0000_000A, 1'b0);
        write_size(6'd2);
        send_row(32'hFFFF_FFFF, 1'b1);
        send_row(32'h0000_0001, 1'b0);
        write_size(6'd5);
        send_row(32'h0000_001F, 1'b1);
        write_size(6'd63);
        send_row(32'hFFFF_FFFF, 1'b1);
        write_size(6'd32);
        send_row(32'hFFFF_FFFF, 1'b0);
        send_row(32'h8000_0000, 1'b1);

        while (rows_sent < ITEM_TARGET) begin
            sel = $urandom_range(19, 0);
            if (sel == 0) begin
                next_size = 6'd0;
            end else if (sel <= 11) begin
                next_size = 6'($urandom_range(6, 1));
            end else if (sel <= 15) begin
                next_size = 6'($urandom_range(12, 7));
            end else if (sel <= 17) begin
                next_size = 6'($urandom_range(31, 13));
            end else if (sel == 18) begin
                next_size = 6'd32;
            end else begin
                next_size = 6'($urandom_range(63, 33));
            end
            write_size(next_size);
            matrices = (sb.active_size() >= 13) ? $urandom_range(2, 1) : $urandom_range(8, 2);
            for (t = 0; t < matrices; t++) begin
                send_random_matrix();
                if ($urandom_range(5, 0) == 0) begin
                    drain();
                end
            end
        end

        @(negedge i_clk);
        start       = 1'b0;
        wait_cycles = 0;
        while (sb.expected_flags.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (settle_cycles(32)) @(posedge i_clk);
        if (sb.expected_flags.size() != 0) begin
            sb.report_mismatch($sformatf("%0d checks never answered", sb.expected_flags.size()));
        end

        $display("Run sent %0d rows over %0d size settings between 0 and 63.",
                 rows_sent, size_writes);
        $display("It compared %0d singularity answers, %0d of them zero blocks.",
                 sb.checks_done, sb.blocks_found);
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
